>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");

`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, ck, rn, cond)
`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and the keyword table of the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int STT_QUEUE_DEPTH = 4;

    // scanner modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NUMBER  = 3'd1;
    localparam logic [2:0] M_WORD    = 3'd2;
    localparam logic [2:0] M_STRING  = 3'd3;
    localparam logic [2:0] M_PENDING = 3'd4;
    localparam logic [2:0] M_HALT    = 3'd5;

    // token kinds
    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_INT      = 6'd1;
    localparam logic [5:0] K_SLASH    = 6'd2;
    localparam logic [5:0] K_PLUS     = 6'd3;
    localparam logic [5:0] K_MINUS    = 6'd4;
    localparam logic [5:0] K_STAR     = 6'd5;
    localparam logic [5:0] K_LBRACKET = 6'd6;
    localparam logic [5:0] K_RBRACKET = 6'd7;
    localparam logic [5:0] K_STRING   = 6'd8;
    localparam logic [5:0] K_BANG     = 6'd9;
    localparam logic [5:0] K_NE       = 6'd10;
    localparam logic [5:0] K_ASSIGN   = 6'd11;
    localparam logic [5:0] K_EQ       = 6'd12;
    localparam logic [5:0] K_GT       = 6'd13;
    localparam logic [5:0] K_GE       = 6'd14;
    localparam logic [5:0] K_SHR      = 6'd15;
    localparam logic [5:0] K_LT       = 6'd16;
    localparam logic [5:0] K_LE       = 6'd17;
    localparam logic [5:0] K_SHL      = 6'd18;
    localparam logic [5:0] K_LBRACE   = 6'd19;
    localparam logic [5:0] K_RBRACE   = 6'd20;
    localparam logic [5:0] K_SEMI     = 6'd21;
    localparam logic [5:0] K_LPAREN   = 6'd22;
    localparam logic [5:0] K_RPAREN   = 6'd23;
    localparam logic [5:0] K_IDENT    = 6'd24;
    localparam logic [5:0] K_KEY0     = 6'd25;
    localparam logic [5:0] K_TEXT     = 6'd39;
    localparam logic [5:0] K_ERROR    = 6'd40;

    // error codes
    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_BAD_CHAR = 2'd1;
    localparam logic [1:0] E_UNTERM   = 2'd2;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    localparam int NUM_KW = 14;

    // keywords packed little endian: first character in bits 7:0
    localparam logic [55:0] KW_TEXT [NUM_KW] = '{
        56'("cnuf"), 56'("stup"), 56'("enon"), 56'("8u"), 56'("61u"),
        56'("23u"), 56'("46u"), 56'("fi"), 56'("elihw"), 56'("nruter"),
        56'("msa__"), 56'("nretxe"), 56'("dekan__"), 56'("cilbup")
    };

    typedef struct packed {
        logic [5:0]         token_kind;
        logic signed [31:0] int_value;
        logic [7:0]         text_char;
        logic [23:0]        line;
        logic [1:0]         error_code;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  pending_op;
        logic [31:0] number_acc;
        logic [55:0] word_prefix;
        logic [3:0]  word_length;
        logic [23:0] line_count;
    } state_t;

    function automatic logic [5:0] word_kind(input logic [55:0] prefix,
                                             input logic [3:0] len);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if (len <= 4'd7 && prefix == KW_TEXT[i])
            begin
                kind = 6'(K_KEY0 + 6'(i));
            end
        end
        return kind;
    endfunction

endpackage

>>> rtl/core/stt_ifs.sv
// ----------------------------------------------------------------------------
// stt_ifs
// Valid/ready channels: source bytes in, token results out.
// ----------------------------------------------------------------------------
interface stt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

interface stt_token_if;
    logic               valid;
    logic               ready;
    logic [5:0]         token_kind;
    logic signed [31:0] int_value;
    logic [7:0]         text_char;
    logic [23:0]        line;
    logic [1:0]         error_code;
    logic               last;

    modport source (output valid, output token_kind, output int_value,
                    output text_char, output line, output error_code,
                    output last, input ready);
    modport sink (input valid, input token_kind, input int_value,
                  input text_char, input line, input error_code,
                  input last, output ready);
endinterface

>>> rtl/core/stt_step.sv
// ----------------------------------------------------------------------------
// stt_step
// Next-state and result logic for one source byte; up to two results.
// ----------------------------------------------------------------------------
module stt_step (
    input  stt_pkg::state_t st,
    input  logic [7:0]      ch,
    output stt_pkg::state_t st_next,
    output logic [1:0]      n_res,
    output stt_pkg::res_t   r0,
    output stt_pkg::res_t   r1
);
    import stt_pkg::*;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic   hit;
        res_t   res;
        state_t st;
    } fresh_t;

    function automatic res_t mk(input logic [5:0] kind, input logic [31:0] ival,
                                input logic [7:0] tc, input logic [1:0] err,
                                input logic [23:0] line);
        res_t r;
        r.token_kind = kind;
        r.int_value  = $signed(ival);
        r.text_char  = tc;
        r.line       = line;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // start of a token from the idle mode
    function automatic fresh_t fresh(input logic [7:0] c, input state_t s);
        fresh_t f;
        f.hit = 1'b0;
        f.st = s;
        f.st.mode = M_IDLE;
        f.res = mk(K_EOF, 32'd0, 8'd0, E_NONE, s.line_count);
        unique case (c)
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:
            begin
                if (s.line_count != LINE_MAX)
                begin
                    f.st.line_count = s.line_count + 24'd1;
                end
            end
            CH_NUL:
            begin
                f.st.mode = M_HALT;
                f.hit = 1'b1;
            end
            CH_QUOTE: f.st.mode = M_STRING;
            "!", "=", ">", "<":
            begin
                f.st.mode = M_PENDING;
                f.st.pending_op = c;
            end
            "/": begin f.hit = 1'b1; f.res.token_kind = K_SLASH; end
            "+": begin f.hit = 1'b1; f.res.token_kind = K_PLUS; end
            "-": begin f.hit = 1'b1; f.res.token_kind = K_MINUS; end
            "*": begin f.hit = 1'b1; f.res.token_kind = K_STAR; end
            "[": begin f.hit = 1'b1; f.res.token_kind = K_LBRACKET; end
            "]": begin f.hit = 1'b1; f.res.token_kind = K_RBRACKET; end
            "{": begin f.hit = 1'b1; f.res.token_kind = K_LBRACE; end
            "}": begin f.hit = 1'b1; f.res.token_kind = K_RBRACE; end
            ";": begin f.hit = 1'b1; f.res.token_kind = K_SEMI; end
            "(": begin f.hit = 1'b1; f.res.token_kind = K_LPAREN; end
            ")": begin f.hit = 1'b1; f.res.token_kind = K_RPAREN; end
            default:
            begin
                if (is_digit(c))
                begin
                    f.st.mode = M_NUMBER;
                    f.st.number_acc = {24'd0, c - CH_ZERO};
                end
                else if (is_word(c))
                begin
                    f.st.mode = M_WORD;
                    f.st.word_prefix = {48'd0, c};
                    f.st.word_length = 4'd1;
                    f.hit = 1'b1;
                    f.res = mk(K_TEXT, 32'd0, c, E_NONE, s.line_count);
                end
                else
                begin
                    f.st.mode = M_HALT;
                    f.hit = 1'b1;
                    f.res = mk(K_ERROR, 32'd0, c, E_BAD_CHAR, s.line_count);
                end
            end
        endcase
        return f;
    endfunction

    fresh_t     f;
    logic [1:0] n;
    res_t       a;
    res_t       b;
    logic [5:0] single_k;
    logic [5:0] pair_k;
    logic       is_term;

    assign is_term = ch == "+" || ch == "-" || ch == "/" || ch == "*" || ch == ";" ||
                     ch == ")" || ch == CH_SPACE || ch == CH_TAB || ch == CH_LF ||
                     ch == CH_CR;

    always_comb
    begin
        f = fresh(ch, st);
        st_next = st;
        n = 2'd0;
        a = mk(K_EOF, 32'd0, 8'd0, E_NONE, st.line_count);
        b = a;
        single_k = K_LT;
        pair_k = K_EOF;
        unique case (st.mode)
            M_IDLE:
            begin
                st_next = f.st;
                n = {1'b0, f.hit};
                a = f.res;
            end
            M_NUMBER:
            begin
                if (is_digit(ch))
                begin
                    st_next.number_acc = {st.number_acc[28:0], 3'b000} +
                                         {st.number_acc[30:0], 1'b0} +
                                         {24'd0, ch - CH_ZERO};
                end
                else if (is_term)
                begin
                    a = mk(K_INT, st.number_acc, 8'd0, E_NONE, st.line_count);
                    st_next = f.st;
                    n = f.hit ? 2'd2 : 2'd1;
                    b = f.res;
                end
                else
                begin
                    st_next.mode = M_HALT;
                    n = 2'd1;
                    a = mk(K_ERROR, 32'd0, ch, E_BAD_CHAR, st.line_count);
                end
            end
            M_WORD:
            begin
                if (is_word(ch) || is_digit(ch))
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        if (st.word_length == 4'(i))
                        begin
                            st_next.word_prefix[8*i +: 8] = ch;
                        end
                    end
                    if (st.word_length < 4'd8)
                    begin
                        st_next.word_length = st.word_length + 4'd1;
                    end
                    n = 2'd1;
                    a = mk(K_TEXT, 32'd0, ch, E_NONE, st.line_count);
                end
                else
                begin
                    a = mk(word_kind(st.word_prefix, st.word_length), 32'd0, 8'd0,
                           E_NONE, st.line_count);
                    st_next = f.st;
                    n = f.hit ? 2'd2 : 2'd1;
                    b = f.res;
                end
            end
            M_STRING:
            begin
                n = 2'd1;
                if (ch == CH_QUOTE)
                begin
                    st_next.mode = M_IDLE;
                    a = mk(K_STRING, 32'd0, 8'd0, E_NONE, st.line_count);
                end
                else if (ch == CH_NUL)
                begin
                    st_next.mode = M_HALT;
                    a = mk(K_ERROR, 32'd0, 8'd0, E_UNTERM, st.line_count);
                end
                else
                begin
                    a = mk(K_TEXT, 32'd0, ch, E_NONE, st.line_count);
                end
            end
            M_PENDING:
            begin
                priority if (st.pending_op == "!")
                begin
                    single_k = K_BANG;
                    if (ch == "=") pair_k = K_NE;
                end
                else if (st.pending_op == "=")
                begin
                    single_k = K_ASSIGN;
                    if (ch == "=") pair_k = K_EQ;
                end
                else if (st.pending_op == ">")
                begin
                    single_k = K_GT;
                    if (ch == "=") pair_k = K_GE;
                    else if (ch == ">") pair_k = K_SHR;
                end
                else
                begin
                    single_k = K_LT;
                    if (ch == "=") pair_k = K_LE;
                    else if (ch == "<") pair_k = K_SHL;
                end
                if (pair_k != K_EOF)
                begin
                    st_next.mode = M_IDLE;
                    n = 2'd1;
                    a.token_kind = pair_k;
                end
                else
                begin
                    a.token_kind = single_k;
                    st_next = f.st;
                    n = f.hit ? 2'd2 : 2'd1;
                    b = f.res;
                end
            end
            default:
            begin
                st_next.mode = M_HALT;
            end
        endcase
        a.last = n == 2'd1;
        b.last = n == 2'd2;
    end

    assign n_res = n;
    assign r0 = a;
    assign r1 = b;

endmodule

>>> rtl/core/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Result queue: takes up to two results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
module stt_queue #(
    parameter int Depth = stt_pkg::STT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_cnt,
    input  stt_pkg::res_t push0,
    input  stt_pkg::res_t push1,
    input  logic          pop,
    output stt_pkg::res_t head,
    output logic          head_valid,
    output logic          room
);
    import stt_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    res_t            slot_reg [Depth];
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] wr_ptr1;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;

    assign wr_ptr1 = nxt(wr_ptr_reg);

    always_comb
    begin
        unique case (push_cnt)
            2'd1:    wr_ptr_next = wr_ptr1;
            2'd2:    wr_ptr_next = nxt(wr_ptr1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? nxt(rd_ptr_reg) : rd_ptr_reg;
        cnt_next = cnt_reg + CntW'(push_cnt) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wr_ptr1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = cnt_reg != '0;
    assign room       = (cnt_reg - CntW'(pop)) <= CntW'(Depth - 2);

endmodule

>>> rtl/core/source_text_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Path: a byte beat passes the input register, then the result queue.
// Throughput: 1 byte per cycle while the queue has room; a byte with two
// results needs two output beats.
// Reset: scanner idle, line count 1, input stage and queue empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_text_tokenizer_unit #(
    parameter int QueueDepth = stt_pkg::STT_QUEUE_DEPTH
) (
    input logic         clk,
    input logic         rst_n,
    stt_text_if.sink    text,
    stt_token_if.source token
);
    import stt_pkg::*;

    logic       hold_v_reg;
    logic [7:0] ch_reg;
    state_t     st_reg;
    state_t     st_next;
    logic [1:0] n_res;
    res_t       r0;
    res_t       r1;
    res_t       head;
    logic       head_valid;
    logic       room;
    logic       proc;
    logic       pop;
    logic [5:0] last_kind;

    assign proc       = hold_v_reg && room;
    assign text.ready = !hold_v_reg || room;
    assign pop        = head_valid && token.ready;

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            ch_reg <= text.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg         <= 1'b0;
            st_reg.mode        <= M_IDLE;
            st_reg.pending_op  <= '0;
            st_reg.number_acc  <= '0;
            st_reg.word_prefix <= '0;
            st_reg.word_length <= '0;
            st_reg.line_count  <= 24'd1;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (proc)
            begin
                hold_v_reg <= 1'b0;
            end
            if (proc)
            begin
                st_reg <= st_next;
            end
        end
    end

    stt_step u_step (
        .st      (st_reg),
        .ch      (ch_reg),
        .st_next (st_next),
        .n_res   (n_res),
        .r0      (r0),
        .r1      (r1)
    );

    stt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (proc ? n_res : 2'd0),
        .push0      (r0),
        .push1      (r1),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .room       (room)
    );

    assign token.valid      = head_valid;
    assign token.token_kind = head.token_kind;
    assign token.int_value  = head.int_value;
    assign token.text_char  = head.text_char;
    assign token.line       = head.line;
    assign token.error_code = head.error_code;
    assign token.last       = head.last;

    assign last_kind = (n_res == 2'd2) ? r1.token_kind : r0.token_kind;

    `ASSERT_IMPL(a_halt_quiet, clk, rst_n, proc && st_reg.mode == M_HALT, n_res == 2'd0)
    `ASSERT_ALWAYS(a_line_nonzero, clk, rst_n, st_reg.line_count != 24'd0)
    `ASSERT_NEXT(a_err_halts, clk, rst_n,
                 proc && n_res != 2'd0 && last_kind == K_ERROR, st_reg.mode == M_HALT)
    `ASSERT_IMPL(a_last_marks, clk, rst_n, proc && n_res == 2'd2, r1.last && !r0.last)

endmodule

>>> sim/stt_token_checker.sv
// ----------------------------------------------------------------------------
// stt_token_checker
// Watches the byte and token channels of the tokenizer. Every byte accepted
// on the input runs through a scanner model kept here, which queues the token
// and echo beats that byte must produce. Every token beat is compared with
// the oldest queued beat. Mismatches and unexpected beats are counted.
// ----------------------------------------------------------------------------
module stt_token_checker import stt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    stt_text_if  text,
    stt_token_if token,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    string keywords [NUM_KW] = '{
        "func", "puts", "none", "u8", "u16", "u32", "u64",
        "if", "while", "return", "__asm", "extern", "__naked", "public"
    };

    logic [2:0]  scan_mode;
    logic [7:0]  held_op;
    logic [31:0] num_acc;
    string       word_text;   // first seven bytes of the current word
    int          word_len;    // saturates at 8
    logic [23:0] line_no;

    res_t        token_q [$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit ends_number(input logic [7:0] c);
        return c == "+" || c == "-" || c == "/" || c == "*" || c == ";" ||
               c == ")" || c == " " || c == "\t" || c == "\n" || c == "\r";
    endfunction

    function automatic void put_token(input logic [5:0] kind, input logic [31:0] value,
                                      input logic [7:0] tc, input logic [1:0] err);
        res_t r;
        r.token_kind = kind;
        r.int_value  = value;
        r.text_char  = tc;
        r.line       = line_no;
        r.error_code = err;
        r.last       = 1'b0;
        token_q.push_back(r);
    endfunction

    function automatic logic [5:0] classify_word();
        logic [5:0] kind;
        kind = K_IDENT;
        if (word_len <= 7)
        begin
            for (int i = 0; i < NUM_KW; i++)
            begin
                if (word_text == keywords[i])
                begin
                    kind = 6'(K_KEY0 + i);
                end
            end
        end
        return kind;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        case (c)
            " ", "\t", "\r": ;
            "\n":
            begin
                if (line_no != LINE_MAX)
                begin
                    line_no = line_no + 24'd1;
                end
            end
            8'h00:
            begin
                scan_mode = M_HALT;
                put_token(K_EOF, 0, 0, E_NONE);
            end
            "\"": scan_mode = M_STRING;
            "!", "=", ">", "<":
            begin
                scan_mode = M_PENDING;
                held_op   = c;
            end
            "/": put_token(K_SLASH, 0, 0, E_NONE);
            "+": put_token(K_PLUS, 0, 0, E_NONE);
            "-": put_token(K_MINUS, 0, 0, E_NONE);
            "*": put_token(K_STAR, 0, 0, E_NONE);
            "[": put_token(K_LBRACKET, 0, 0, E_NONE);
            "]": put_token(K_RBRACKET, 0, 0, E_NONE);
            "{": put_token(K_LBRACE, 0, 0, E_NONE);
            "}": put_token(K_RBRACE, 0, 0, E_NONE);
            ";": put_token(K_SEMI, 0, 0, E_NONE);
            "(": put_token(K_LPAREN, 0, 0, E_NONE);
            ")": put_token(K_RPAREN, 0, 0, E_NONE);
            default:
            begin
                if (is_digit(c))
                begin
                    scan_mode = M_NUMBER;
                    num_acc   = 32'(c - "0");
                end
                else if (is_alpha(c) || c == "_")
                begin
                    scan_mode = M_WORD;
                    word_text = $sformatf("%c", c);
                    word_len  = 1;
                    put_token(K_TEXT, 0, c, E_NONE);
                end
                else
                begin
                    scan_mode = M_HALT;
                    put_token(K_ERROR, 0, c, E_BAD_CHAR);
                end
            end
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        int         base;
        logic [5:0] single;
        logic [5:0] pair;
        bit         paired;
        base   = token_q.size();
        paired = 1'b0;
        case (scan_mode)
            M_NUMBER:
            begin
                if (is_digit(c))
                begin
                    num_acc = num_acc * 32'd10 + 32'(c - "0");
                end
                else if (ends_number(c))
                begin
                    put_token(K_INT, num_acc, 0, E_NONE);
                    scan_mode = M_IDLE;
                    scan_fresh(c);
                end
                else
                begin
                    scan_mode = M_HALT;
                    put_token(K_ERROR, 0, c, E_BAD_CHAR);
                end
            end
            M_WORD:
            begin
                if (is_alpha(c) || is_digit(c) || c == "_")
                begin
                    if (word_len < 7)
                    begin
                        word_text = $sformatf("%s%c", word_text, c);
                    end
                    if (word_len < 8)
                    begin
                        word_len++;
                    end
                    put_token(K_TEXT, 0, c, E_NONE);
                end
                else
                begin
                    put_token(classify_word(), 0, 0, E_NONE);
                    scan_mode = M_IDLE;
                    scan_fresh(c);
                end
            end
            M_STRING:
            begin
                if (c == "\"")
                begin
                    scan_mode = M_IDLE;
                    put_token(K_STRING, 0, 0, E_NONE);
                end
                else if (c == 8'h00)
                begin
                    scan_mode = M_HALT;
                    put_token(K_ERROR, 0, 0, E_UNTERM);
                end
                else
                begin
                    put_token(K_TEXT, 0, c, E_NONE);
                end
            end
            M_PENDING:
            begin
                scan_mode = M_IDLE;
                case (held_op)
                    "!":
                    begin
                        single = K_BANG;
                        pair   = K_NE;
                        paired = (c == "=");
                    end
                    "=":
                    begin
                        single = K_ASSIGN;
                        pair   = K_EQ;
                        paired = (c == "=");
                    end
                    ">":
                    begin
                        single = K_GT;
                        pair   = (c == ">") ? K_SHR : K_GE;
                        paired = (c == "=" || c == ">");
                    end
                    default:
                    begin
                        single = K_LT;
                        pair   = (c == "<") ? K_SHL : K_LE;
                        paired = (c == "=" || c == "<");
                    end
                endcase
                if (paired)
                begin
                    put_token(pair, 0, 0, E_NONE);
                end
                else
                begin
                    put_token(single, 0, 0, E_NONE);
                    scan_fresh(c);
                end
            end
            M_IDLE: scan_fresh(c);
            default: scan_mode = M_HALT;
        endcase
        if (token_q.size() > base)
        begin
            token_q[token_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic string show(input res_t r);
        return $sformatf("kind %0d value %0d char %02h line %0d err %0d last %0d",
                         r.token_kind, r.int_value, r.text_char, r.line,
                         r.error_code, r.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            scan_mode = M_IDLE;
            held_op   = 8'h00;
            num_acc   = 32'd0;
            word_text = "";
            word_len  = 0;
            line_no   = 24'd1;
            token_q.delete();
            pending   = 0;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                scan_byte(text.ch);
            end
            if (token.valid && token.ready)
            begin
                got.token_kind = token.token_kind;
                got.int_value  = token.int_value;
                got.text_char  = token.text_char;
                got.line       = token.line;
                got.error_code = token.error_code;
                got.last       = token.last;
                if (token_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: unexpected token beat: %s", $time, show(got));
                    end
                    fail_count++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: token mismatch\n  expected %s\n  actual   %s",
                                     $time, show(want), show(got));
                        end
                        fail_count++;
                    end
                end
            end
            pending = token_q.size();
        end
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Source text tokenizer testbench. Builds one source text: a short directed
// opening, a long run of random well-formed tokens, then one random way of
// stopping the scanner (end of text, bad byte, open string, bad number end,
// operator or word at end), then bytes the halted block must ignore. Both
// channels stall at random; the checker predicts and compares every token beat.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        END_EOF,
        END_BAD_CHAR,
        END_OPEN_STRING,
        END_BAD_NUMBER,
        END_OP_EOF,
        END_WORD_EOF
    } ending_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    int   quiet_left;

    logic [7:0] src [$];

    string kw_pool [14] = '{
        "func", "puts", "none", "u8", "u16", "u32", "u64",
        "if", "while", "return", "__asm", "extern", "__naked", "public"
    };

    stt_text_if  text_ch ();
    stt_token_if token_ch ();

    source_text_tokenizer_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .token (token_ch)
    );

    stt_token_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .token      (token_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            src.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
        begin
            return 8'("a" + r);
        end
        if (r < 52)
        begin
            return 8'("A" + r - 26);
        end
        if (r == 52)
        begin
            return "_";
        end
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            return "\t";
        end
        if (r == 1)
        begin
            return "\r";
        end
        return (r < 4) ? " " : "\n";
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++)
        begin
            src.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_number();
        string seps;
        seps = "+-/*;) \t\r\n";
        add_digits(($urandom_range(0, 6) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4));
        src.push_back(seps[$urandom_range(0, seps.len() - 1)]);
    endfunction

    function automatic void add_word();
        string w;
        int    n;
        int    r;
        if ($urandom_range(0, 1) == 1)
        begin
            w = kw_pool[$urandom_range(0, 13)];
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                w = $sformatf("%s%c", w, word_char(1'b0));
            end
            else if (r == 1 && w.len() > 1)
            begin
                w = w.substr(0, w.len() - 2);
            end
            push_text(w);
        end
        else
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
            for (int i = 0; i < n; i++)
            begin
                src.push_back(word_char(i == 0));
            end
        end
        if ($urandom_range(0, 9) < 7)
        begin
            src.push_back(blank_char());
        end
    endfunction

    function automatic void add_string();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        src.push_back("\"");
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(1, 255));
            if (b == "\"")
            begin
                b = "\n";
            end
            src.push_back(b);
        end
        src.push_back("\"");
    endfunction

    function automatic void add_operator();
        string      singles;
        string      pends;
        logic [7:0] p;
        int         r;
        singles = "/+-*[]{};()";
        pends   = "!=<>";
        if ($urandom_range(0, 1) == 0)
        begin
            src.push_back(singles[$urandom_range(0, singles.len() - 1)]);
        end
        else
        begin
            p = pends[$urandom_range(0, 3)];
            src.push_back(p);
            r = $urandom_range(0, 2);
            if (r == 0)
            begin
                src.push_back("=");
            end
            else if (r == 1 && (p == ">" || p == "<"))
            begin
                src.push_back(p);
            end
        end
    endfunction

    function automatic void add_ending();
        ending_t style;
        string   bad;
        int      r;
        style = ending_t'($urandom_range(0, 5));
        bad   = "@#$%&.,:?^|~'";
        case (style)
            END_EOF: src.push_back(8'h00);
            END_BAD_CHAR:
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                begin
                    src.push_back(8'($urandom_range(128, 255)));
                end
                else if (r == 1)
                begin
                    src.push_back(8'($urandom_range(1, 8)));
                end
                else
                begin
                    src.push_back(bad[$urandom_range(0, bad.len() - 1)]);
                end
            end
            END_OPEN_STRING:
            begin
                src.push_back("\"");
                for (int i = 0; i < $urandom_range(0, 3); i++)
                begin
                    src.push_back(word_char(1'b0));
                end
                src.push_back(8'h00);
            end
            END_BAD_NUMBER:
            begin
                bad = "aZ_(@[=<{\"";
                add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 3) == 0)
                begin
                    src.push_back(8'h00);
                end
                else
                begin
                    src.push_back(bad[$urandom_range(0, bad.len() - 1)]);
                end
            end
            END_OP_EOF:
            begin
                bad = "!=<>";
                src.push_back(bad[$urandom_range(0, 3)]);
                src.push_back(8'h00);
            end
            default:
            begin
                src.push_back(word_char(1'b1));
                src.push_back(8'h00);
            end
        endcase
    endfunction

    function automatic int source_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.ch    <= b;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // token sink: ready bursts, short stalls, a few long ones
    initial
    begin
        int r;
        int n;
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                token_ch.ready <= 1'b0;
                n = $urandom_range(1, 3);
            end
            else if (r < 16)
            begin
                token_ch.ready <= 1'b0;
                n = $urandom_range(10, 40);
            end
            else
            begin
                token_ch.ready <= 1'b1;
                n = (r >= 90) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            end
            repeat (n - 1) @(negedge clk);
        end
    end

    initial
    begin
        int r;
        text_ch.valid = 1'b0;
        text_ch.ch    = 8'h00;
        rst_n         = 1'b0;
        quiet_left    = 0;

        // directed: wrap to -1, string with extreme bytes and a newline,
        // longest keyword, then a two-byte operator
        push_text("4294967295+");
        src.push_back("\"");
        src.push_back(8'hFF);
        src.push_back(8'h01);
        src.push_back("\n");
        src.push_back("\"");
        push_text("__naked>=");

        while (src.size() < 388)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                add_number();
            end
            else if (r < 45)
            begin
                add_word();
            end
            else if (r < 58)
            begin
                add_string();
            end
            else if (r < 85)
            begin
                add_operator();
            end
            else
            begin
                src.push_back(blank_char());
            end
            if ($urandom_range(0, 1) == 0)
            begin
                src.push_back(blank_char());
            end
        end
        add_ending();
        // halted block must ignore these
        for (int i = 0; i < 6; i++)
        begin
            src.push_back(8'($urandom_range(0, 255)));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (src[i])
        begin
            send_byte(src[i]);
        end
        text_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
